// File: rtl/core/fbpa_pkg.sv
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int CNT_W   = 9;
    localparam int ST_W    = 3;
    localparam int OP_W    = 2;
    localparam int CIDX_W  = 2;
    localparam int ALU_W   = ADDR_W + 1;
    localparam int RSIZE_W = SIZE_W + 1;
    localparam int PROD_W  = RSIZE_W + CNT_W;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_NULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_PARAM    = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BYTES = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_COUNT = 2'd2;

    localparam logic [RSIZE_W-1:0] ROUND_ADD  = 17'd3;
    localparam logic [RSIZE_W-1:0] ROUND_MASK = ~17'd3;
    localparam logic [RSIZE_W-1:0] MIN_SIZE   = 17'd4;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

endpackage

// File: rtl/core/fbpa_channel_if.sv
`timescale 1ns / 1ps

interface fbpa_req_if;
    logic                        valid;
    logic                        ready;
    logic [fbpa_pkg::OP_W-1:0]   op;
    logic [fbpa_pkg::ADDR_W-1:0] block_address;

    modport source (output valid, output op, output block_address, input ready);
    modport sink (input valid, input op, input block_address, output ready);
endinterface

interface fbpa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [fbpa_pkg::ST_W-1:0]   status;
    logic [fbpa_pkg::ADDR_W-1:0] granted_address;
    logic [fbpa_pkg::CNT_W-1:0]  blocks_free;

    modport source (output valid, output status, output granted_address,
                    output blocks_free, input ready);
    modport sink (input valid, input status, input granted_address,
                  input blocks_free, output ready);
endinterface

// File: rtl/core/fixed_block_pool_allocator_core.sv
`timescale 1ns / 1ps

// Fixed-size block pool allocator with a last-in-first-out stack of free addresses.
// Requests arrive on req as valid/ready beats carrying op and block_address; each
// request gives exactly one result beat on rsp with status, granted_address and
// blocks_free. The user must write base, block size and block count on the config
// port only while idle; the block does not enforce it. An init request then checks
// them and fills the stack. One request is worked at a time under a small sequencer
// around one shared adder. Alloc and undefined ops pass through the decode and done
// states, free may add an end-of-region check, and a good init adds a multiply, an
// end check and a fill, one stack write per cycle through the single memory port.
// req.ready is high only while the sequencer is idle. A finished result sits in an
// output register; a new request is taken while that beat still waits, and the
// sequencer holds its next result until rsp is taken.
// Reset clears the free count, the pool bounds and the configuration registers, so
// the pool starts empty; the stack memory itself is not cleared.
module fixed_block_pool_allocator_core #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fbpa_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]   cfg_data,
    fbpa_req_if.sink                      req,
    fbpa_rsp_if.source                    rsp
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int TW = $clog2(MAX_BLOCKS + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_FREE_END = 3'd2;
    localparam logic [2:0] S_INIT_MUL = 3'd3;
    localparam logic [2:0] S_INIT_END = 3'd4;
    localparam logic [2:0] S_FILL     = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [fbpa_pkg::ADDR_W-1:0]  cfg_base_reg;
    logic [fbpa_pkg::SIZE_W-1:0]  cfg_bytes_reg;
    logic [fbpa_pkg::CNT_W-1:0]   cfg_count_reg;

    logic [TW-1:0]                free_total_reg, free_total_next;
    logic [fbpa_pkg::ADDR_W-1:0]  region_start_reg, region_start_next;
    logic [fbpa_pkg::ALU_W-1:0]   region_end_reg, region_end_next;

    logic [fbpa_pkg::OP_W-1:0]    op_reg, op_next;
    logic [fbpa_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [fbpa_pkg::RSIZE_W-1:0] size_reg, size_next;
    logic [fbpa_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [fbpa_pkg::ALU_W-1:0]   acc_reg, acc_next;
    logic [TW-1:0]                fill_reg, fill_next;
    logic [fbpa_pkg::ST_W-1:0]    res_status_reg, res_status_next;
    logic                         res_gnt_reg, res_gnt_next;

    logic                         out_valid_reg, out_valid_next;
    logic [fbpa_pkg::ST_W-1:0]    out_status_reg, out_status_next;
    logic [fbpa_pkg::ADDR_W-1:0]  out_gnt_reg, out_gnt_next;
    logic [fbpa_pkg::CNT_W-1:0]   out_free_reg, out_free_next;

    fbpa_pkg::alu_req_t           alu_req;
    logic [fbpa_pkg::ALU_W:0]     alu_res;
    logic                         alu_borrow;

    logic                         ram_en, ram_we;
    logic [AW-1:0]                ram_addr;
    logic [fbpa_pkg::ADDR_W-1:0]  ram_wdata, ram_rdata;

    logic                         slot_free;
    logic [TW-1:0]                ft_dec;
    logic [TW-1:0]                init_count;
    logic [fbpa_pkg::RSIZE_W-1:0] size_round;

    fbpa_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    fbpa_ram #(
        .WIDTH (fbpa_pkg::ADDR_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign alu_borrow = alu_res[fbpa_pkg::ALU_W];
    assign slot_free  = !out_valid_reg || rsp.ready;
    assign ft_dec     = free_total_reg - TW'(1);
    assign init_count = TW'(cfg_count_reg);
    assign size_round = alu_res[fbpa_pkg::RSIZE_W-1:0] & fbpa_pkg::ROUND_MASK;

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.granted_address = out_gnt_reg;
    assign rsp.blocks_free     = out_free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_base_reg  <= '0;
            cfg_bytes_reg <= '0;
            cfg_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fbpa_pkg::CFG_BASE:  cfg_base_reg  <= cfg_data;
                fbpa_pkg::CFG_BYTES: cfg_bytes_reg <= cfg_data[fbpa_pkg::SIZE_W-1:0];
                fbpa_pkg::CFG_COUNT: cfg_count_reg <= cfg_data[fbpa_pkg::CNT_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        free_total_next   = free_total_reg;
        region_start_next = region_start_reg;
        region_end_next   = region_end_reg;
        op_next           = op_reg;
        addr_next         = addr_reg;
        size_next         = size_reg;
        prod_next         = prod_reg;
        acc_next          = acc_reg;
        fill_next         = fill_reg;
        res_status_next   = res_status_reg;
        res_gnt_next      = res_gnt_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_status_next   = out_status_reg;
        out_gnt_next      = out_gnt_reg;
        out_free_next     = out_free_reg;
        alu_req.a         = fbpa_pkg::ALU_W'(addr_reg);
        alu_req.b         = fbpa_pkg::ALU_W'(region_start_reg);
        alu_req.sub       = 1'b1;
        ram_en            = 1'b0;
        ram_we            = 1'b0;
        ram_addr          = free_total_reg[AW-1:0];
        ram_wdata         = addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.op;
                    addr_next  = req.block_address;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_gnt_next    = 1'b0;
                res_status_next = fbpa_pkg::ST_OK;
                state_next      = S_DONE;
                unique case (op_reg)
                    fbpa_pkg::OP_ALLOC:
                    begin
                        if (free_total_reg == '0)
                        begin
                            res_status_next = fbpa_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ram_en          = 1'b1;
                            ram_addr        = ft_dec[AW-1:0];
                            free_total_next = ft_dec;
                            res_gnt_next    = 1'b1;
                        end
                    end

                    fbpa_pkg::OP_FREE:
                    begin
                        if (addr_reg == '0)
                        begin
                            res_status_next = fbpa_pkg::ST_NULL;
                        end
                        else if (alu_borrow)
                        begin
                            res_status_next = fbpa_pkg::ST_PARAM;
                        end
                        else
                        begin
                            state_next = S_FREE_END;
                        end
                    end

                    fbpa_pkg::OP_INIT:
                    begin
                        alu_req.a   = fbpa_pkg::ALU_W'(cfg_bytes_reg);
                        alu_req.b   = fbpa_pkg::ALU_W'(fbpa_pkg::ROUND_ADD);
                        alu_req.sub = 1'b0;
                        if (cfg_base_reg == '0 || cfg_bytes_reg == '0 || cfg_count_reg == '0
                            || 32'(cfg_count_reg) > 32'(MAX_BLOCKS))
                        begin
                            res_status_next = fbpa_pkg::ST_PARAM;
                        end
                        else
                        begin
                            size_next  = (size_round < fbpa_pkg::MIN_SIZE) ?
                                         fbpa_pkg::MIN_SIZE : size_round;
                            state_next = S_INIT_MUL;
                        end
                    end

                    default:
                    begin
                        res_status_next = fbpa_pkg::ST_PARAM;
                    end
                endcase
            end

            S_FREE_END:
            begin
                alu_req.b  = region_end_reg;
                state_next = S_DONE;
                if (!alu_borrow)
                begin
                    res_status_next = fbpa_pkg::ST_PARAM;
                end
                else if (free_total_reg == TW'(MAX_BLOCKS))
                begin
                    res_status_next = fbpa_pkg::ST_OVERFLOW;
                end
                else
                begin
                    ram_en          = 1'b1;
                    ram_we          = 1'b1;
                    free_total_next = free_total_reg + TW'(1);
                end
            end

            S_INIT_MUL:
            begin
                prod_next  = fbpa_pkg::PROD_W'(size_reg) * fbpa_pkg::PROD_W'(cfg_count_reg);
                state_next = S_INIT_END;
            end

            S_INIT_END:
            begin
                alu_req.a   = fbpa_pkg::ALU_W'(cfg_base_reg);
                alu_req.b   = fbpa_pkg::ALU_W'(prod_reg);
                alu_req.sub = 1'b0;
                if (alu_res[fbpa_pkg::ALU_W-1] && alu_res[fbpa_pkg::ADDR_W-1:0] != '0)
                begin
                    res_status_next = fbpa_pkg::ST_PARAM;
                    state_next      = S_DONE;
                end
                else
                begin
                    region_start_next = cfg_base_reg;
                    region_end_next   = alu_res[fbpa_pkg::ALU_W-1:0];
                    acc_next          = fbpa_pkg::ALU_W'(cfg_base_reg);
                    fill_next         = '0;
                    state_next        = S_FILL;
                end
            end

            S_FILL:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = fbpa_pkg::ALU_W'(size_reg);
                alu_req.sub = 1'b0;
                ram_en      = 1'b1;
                ram_we      = 1'b1;
                ram_addr    = fill_reg[AW-1:0];
                ram_wdata   = acc_reg[fbpa_pkg::ADDR_W-1:0];
                acc_next    = alu_res[fbpa_pkg::ALU_W-1:0];
                fill_next   = fill_reg + TW'(1);
                if (fill_reg == init_count - TW'(1))
                begin
                    free_total_next = init_count;
                    res_status_next = fbpa_pkg::ST_OK;
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_gnt_next    = res_gnt_reg ? ram_rdata : '0;
                    out_free_next   = fbpa_pkg::CNT_W'(free_total_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            free_total_reg   <= '0;
            region_start_reg <= '0;
            region_end_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            free_total_reg   <= free_total_next;
            region_start_reg <= region_start_next;
            region_end_reg   <= region_end_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        size_reg       <= size_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        fill_reg       <= fill_next;
        res_status_reg <= res_status_next;
        res_gnt_reg    <= res_gnt_next;
        out_status_reg <= out_status_next;
        out_gnt_reg    <= out_gnt_next;
        out_free_reg   <= out_free_next;
    end

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_total_reg) <= 32'(MAX_BLOCKS))
        else $error("free count exceeds pool depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_DECODE))
        else $error("accepted request did not start decoding");

    a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && slot_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished result was not loaded into the output register");

    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (fill_reg < init_count))
        else $error("stack fill ran past the block count");

endmodule

// File: rtl/core/fbpa_ram.sv
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                          clk,
    input  logic                                          en,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
    input  logic [WIDTH-1:0]                              wdata,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/fbpa_alu.sv
`timescale 1ns / 1ps

module fbpa_alu (
    input  fbpa_pkg::alu_req_t          req,
    output logic [fbpa_pkg::ALU_W:0]    res
);

    always_comb
    begin
        if (req.sub)
        begin
            res = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            res = {1'b0, req.a} + {1'b0, req.b};
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int OP_W    = fbpa_pkg::OP_W;
    localparam int ADDR_W  = fbpa_pkg::ADDR_W;
    localparam int ST_W    = fbpa_pkg::ST_W;
    localparam int CNT_W   = fbpa_pkg::CNT_W;
    localparam int CIDX_W  = fbpa_pkg::CIDX_W;
    localparam int SIZE_W  = fbpa_pkg::SIZE_W;
    localparam int RSIZE_W = fbpa_pkg::RSIZE_W;

    localparam logic [OP_W-1:0] OP_ALLOC = fbpa_pkg::OP_ALLOC;
    localparam logic [OP_W-1:0] OP_FREE  = fbpa_pkg::OP_FREE;
    localparam logic [OP_W-1:0] OP_INIT  = fbpa_pkg::OP_INIT;

    localparam logic [ST_W-1:0] ST_OK       = fbpa_pkg::ST_OK;
    localparam logic [ST_W-1:0] ST_NULL     = fbpa_pkg::ST_NULL;
    localparam logic [ST_W-1:0] ST_PARAM    = fbpa_pkg::ST_PARAM;
    localparam logic [ST_W-1:0] ST_EMPTY    = fbpa_pkg::ST_EMPTY;
    localparam logic [ST_W-1:0] ST_OVERFLOW = fbpa_pkg::ST_OVERFLOW;

    localparam logic [CIDX_W-1:0] CFG_BASE  = fbpa_pkg::CFG_BASE;
    localparam logic [CIDX_W-1:0] CFG_BYTES = fbpa_pkg::CFG_BYTES;
    localparam logic [CIDX_W-1:0] CFG_COUNT = fbpa_pkg::CFG_COUNT;

    localparam logic [RSIZE_W-1:0] ROUND_ADD  = fbpa_pkg::ROUND_ADD;
    localparam logic [RSIZE_W-1:0] ROUND_MASK = fbpa_pkg::ROUND_MASK;
    localparam logic [RSIZE_W-1:0] MIN_SIZE   = fbpa_pkg::MIN_SIZE;

    localparam int POOL_DEPTH   = 256;
    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_LIMIT  = 5000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 8;

    localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        bit                reuse;
    } pool_request_t;

    typedef struct {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] granted;
        logic [CNT_W-1:0]  blocks_left;
    } pool_reply_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0] cfg_data;

    fbpa_req_if req_ch();
    fbpa_rsp_if rsp_ch();

    fixed_block_pool_allocator_core #(
        .MAX_BLOCKS(POOL_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    // Shadow of the allocator state and of the configuration registers.
    logic [ADDR_W-1:0] shadow_stack [POOL_DEPTH];
    int unsigned       shadow_free;
    logic [ADDR_W-1:0] shadow_lo;
    logic [ADDR_W:0]   shadow_hi;
    logic [ADDR_W-1:0] set_base;
    logic [SIZE_W-1:0] set_bytes;
    logic [CNT_W-1:0]  set_count;
    logic [63:0]       shape_span;

    logic [ADDR_W-1:0] handed_out [$];
    pool_request_t     request_backlog [$];
    pool_reply_t       replies_due [$];

    int unsigned items_queued;
    int unsigned req_accepted;
    int unsigned req_retired;
    int unsigned fail_count;
    int unsigned quiet_cycles;
    int unsigned n_grants;
    int unsigned n_returns;
    int unsigned n_builds;
    int unsigned n_refused;
    int unsigned n_settings;
    int unsigned long_holds;

    pool_request_t cur_req;
    pool_reply_t   due;
    bit            holding;
    int unsigned   send_gap;
    int unsigned   hold_left;
    bit            send_gaps;
    bit            recv_gaps;
    bit            long_hold_req;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic pool_reply_t apply_pool_request(logic [OP_W-1:0] op,
                                                       logic [ADDR_W-1:0] addr);
        pool_reply_t        rep;
        logic [RSIZE_W-1:0] rsize;
        logic [63:0]        span_end;
        int                 k;
        rep.status  = ST_OK;
        rep.granted = '0;
        case (op)
            OP_ALLOC:
            begin
                if (shadow_free == 0)
                    rep.status = ST_EMPTY;
                else
                begin
                    shadow_free--;
                    rep.granted = shadow_stack[shadow_free];
                    handed_out.push_back(rep.granted);
                end
            end
            OP_FREE:
            begin
                if (addr == '0)
                    rep.status = ST_NULL;
                else if (addr < shadow_lo || {1'b0, addr} >= shadow_hi)
                    rep.status = ST_PARAM;
                else if (shadow_free >= POOL_DEPTH)
                    rep.status = ST_OVERFLOW;
                else
                begin
                    shadow_stack[shadow_free] = addr;
                    shadow_free++;
                end
            end
            OP_INIT:
            begin
                rsize = ({1'b0, set_bytes} + ROUND_ADD) & ROUND_MASK;
                if (rsize < MIN_SIZE)
                    rsize = MIN_SIZE;
                span_end = 64'(set_base) + 64'(rsize) * 64'(set_count);
                if (set_base == '0 || set_bytes == '0 || set_count == '0 ||
                    set_count > POOL_DEPTH || span_end > 64'h1_0000_0000)
                    rep.status = ST_PARAM;
                else
                begin
                    shadow_lo = set_base;
                    shadow_hi = span_end[ADDR_W:0];
                    for (k = 0; k < set_count; k++)
                        shadow_stack[k] = set_base + ADDR_W'(k) * ADDR_W'(rsize);
                    shadow_free = set_count;
                    handed_out.delete();
                end
            end
            default:
                rep.status = ST_PARAM;
        endcase
        if (rep.status != ST_OK)
            n_refused++;
        else if (op == OP_ALLOC)
            n_grants++;
        else if (op == OP_FREE)
            n_returns++;
        else
            n_builds++;
        rep.blocks_left = CNT_W'(shadow_free);
        return rep;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("result beat with nothing expected: status %0d granted_address %h",
                           rsp_ch.status, rsp_ch.granted_address);
                    fail_count++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (rsp_ch.status !== due.status)
                    begin
                        $error("status expected %0d got %0d", due.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.granted_address !== due.granted)
                    begin
                        $error("granted_address expected %h got %h",
                               due.granted, rsp_ch.granted_address);
                        fail_count++;
                    end
                    if (rsp_ch.blocks_free !== due.blocks_left)
                    begin
                        $error("blocks_free expected %0d got %0d",
                               due.blocks_left, rsp_ch.blocks_free);
                        fail_count++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                replies_due.push_back(apply_pool_request(req_ch.op, req_ch.block_address));
                req_accepted++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL fixed_block_pool_allocator_core");
            $finish;
        end
    end

    // A reused free takes one of the addresses handed out so far, picked when the
    // beat is first offered.
    always @(negedge clk)
    begin
        if (holding && req_accepted != req_retired)
        begin
            req_retired++;
            holding  = 1'b0;
            send_gap = send_gaps ? pick_gap() : 0;
        end
        if (!holding)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (request_backlog.size() > 0)
            begin
                cur_req = request_backlog.pop_front();
                if (cur_req.reuse && handed_out.size() > 0)
                begin
                    send_gap = $urandom_range(0, handed_out.size() - 1);
                    cur_req.addr = handed_out[send_gap];
                    handed_out.delete(send_gap);
                    send_gap = 0;
                end
                holding = 1'b1;
            end
        end
        req_ch.valid         <= holding;
        req_ch.op            <= cur_req.op;
        req_ch.block_address <= cur_req.addr;
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD - 1;
            long_holds++;
            rsp_ch.ready <= 1'b0;
        end
        else if (recv_gaps && $urandom_range(0, 99) < 30)
        begin
            hold_left = pick_gap();
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    task automatic add_req(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr, bit reuse);
        pool_request_t item;
        item.op    = op;
        item.addr  = addr;
        item.reuse = reuse;
        request_backlog.push_back(item);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (req_accepted != items_queued || replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [ADDR_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BASE:  set_base  = data;
            CFG_BYTES: set_bytes = data[SIZE_W-1:0];
            CFG_COUNT: set_count = data[CNT_W-1:0];
            default:   ;
        endcase
    endtask

    task automatic set_pool(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] bytes,
                            logic [CNT_W-1:0] count);
        wait_idle();
        write_reg(CFG_BASE, base);
        write_reg(CFG_BYTES, ADDR_W'(bytes));
        write_reg(CFG_COUNT, ADDR_W'(count));
        n_settings++;
    endtask

    task automatic pick_pool_shape(output logic [ADDR_W-1:0] base,
                                   output logic [SIZE_W-1:0] bytes,
                                   output logic [CNT_W-1:0] count);
        int unsigned pick;
        logic [63:0] rsize;
        pick  = $urandom_range(0, 99);
        bytes = SIZE_W'($urandom_range(1, 40));
        count = CNT_W'($urandom_range(1, 12));
        if (pick >= 70 && pick < 78)
        begin
            bytes = SIZE_W'($urandom_range(1, 16));
            count = CNT_W'($urandom_range(200, POOL_DEPTH));
        end
        else if (pick >= 78 && pick < 88)
            bytes = SIZE_W'($urandom_range(1, 16'hFFFF));
        rsize      = (64'(bytes) + 64'd3) & ~64'd3;
        shape_span = rsize * 64'(count);
        base = ADDR_W'($urandom_range(1, 32'(64'h1_0000_0000 - shape_span)));
        if (pick >= 94)
            base = ADDR_W'(64'h1_0000_0000 - shape_span);
        else if (pick >= 88)
        begin
            case ($urandom_range(0, 4))
                0: base = '0;
                1: bytes = '0;
                2: count = '0;
                3: count = CNT_W'($urandom_range(POOL_DEPTH + 1, 511));
                default: base = ADDR_W'(64'h1_0000_0000 - shape_span +
                                        64'($urandom_range(1, 32'(shape_span) - 1)));
            endcase
        end
    endtask

    task automatic queue_round(int unsigned n);
        int unsigned       j;
        int unsigned       pick;
        logic [ADDR_W-1:0] in_range;
        logic [ADDR_W-1:0] pool_end;
        for (j = 0; j < n; j++)
        begin
            pick     = $urandom_range(0, 99);
            pool_end = set_base + ADDR_W'(shape_span);
            in_range = ADDR_W'($urandom_range(0, 32'(shape_span) - 1));
            if ($urandom_range(0, 3) != 0)
                in_range = in_range & ~ADDR_W'(3);
            in_range = set_base + in_range;
            if (pick < 42)
                add_req(OP_ALLOC, ADDR_W'($urandom()), 1'b0);
            else if (pick < 72)
                add_req(OP_FREE, in_range, 1'b1);
            else if (pick < 82)
                add_req(OP_FREE, in_range, 1'b0);
            else if (pick < 86)
                add_req(OP_FREE, '0, 1'b0);
            else if (pick < 91)
                add_req(OP_FREE, ADDR_W'($urandom()), 1'b0);
            else if (pick < 96)
            begin
                case ($urandom_range(0, 3))
                    0: add_req(OP_FREE, set_base - 1, 1'b0);
                    1: add_req(OP_FREE, set_base, 1'b0);
                    2: add_req(OP_FREE, pool_end - 1, 1'b0);
                    default: add_req(OP_FREE, pool_end, 1'b0);
                endcase
            end
            else if (pick < 98)
                add_req(OP_UNDEF, ADDR_W'($urandom()), 1'b0);
            else
                add_req(OP_INIT, ADDR_W'($urandom()), 1'b0);
        end
    endtask

    initial
    begin : stimulus
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] bytes;
        logic [CNT_W-1:0]  count;
        int unsigned       directed_total;
        int unsigned       round;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_BASE;
        cfg_data             = '0;
        req_ch.valid         = 1'b0;
        req_ch.op            = OP_ALLOC;
        req_ch.block_address = '0;
        rsp_ch.ready         = 1'b0;
        cur_req.op           = OP_ALLOC;
        cur_req.addr         = '0;
        cur_req.reuse        = 1'b0;
        holding              = 1'b0;
        send_gap             = 0;
        hold_left            = 0;
        send_gaps            = 1'b1;
        recv_gaps            = 1'b1;
        long_hold_req        = 1'b0;
        shadow_free          = 0;
        shadow_lo            = '0;
        shadow_hi            = '0;
        set_base             = '0;
        set_bytes            = '0;
        set_count            = '0;
        shape_span           = 64'd4;
        items_queued         = 0;
        req_accepted         = 0;
        req_retired          = 0;
        fail_count           = 0;
        quiet_cycles         = 0;
        n_grants             = 0;
        n_returns            = 0;
        n_builds             = 0;
        n_refused            = 0;
        n_settings           = 0;
        long_holds           = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Pool untouched since reset: empty, null free, free out of range, undefined op, init refused.
        add_req(OP_ALLOC, '0, 1'b0);
        add_req(OP_FREE, '0, 1'b0);
        add_req(OP_FREE, '1, 1'b0);
        add_req(OP_UNDEF, '1, 1'b0);
        add_req(OP_INIT, '0, 1'b0);

        set_pool(32'h0000_1000, 16'd1, 9'd3);
        add_req(OP_INIT, '0, 1'b0);
        repeat (4) add_req(OP_ALLOC, '0, 1'b0);
        add_req(OP_FREE, 32'h0000_1000, 1'b0);
        add_req(OP_FREE, 32'h0000_1003, 1'b0);
        add_req(OP_FREE, 32'h0000_100C, 1'b0);
        add_req(OP_FREE, 32'h0000_0FFF, 1'b0);

        // The region end may reach the top of the address space but not pass it.
        set_pool(32'hFFFF_FF00, 16'd4, 9'd65);
        add_req(OP_INIT, '0, 1'b0);
        set_pool(32'hFFFF_FF00, 16'd4, 9'd64);
        add_req(OP_INIT, '0, 1'b0);
        add_req(OP_ALLOC, '0, 1'b0);

        set_pool(32'h0000_0100, 16'hFFFF, 9'd256);
        add_req(OP_INIT, '0, 1'b0);
        add_req(OP_FREE, 32'h0000_0200, 1'b0);
        add_req(OP_ALLOC, '0, 1'b0);

        set_pool(32'h0000_0040, 16'd8, 9'd0);
        add_req(OP_INIT, '0, 1'b0);
        set_pool(32'h0000_0040, 16'd8, 9'd257);
        add_req(OP_INIT, '0, 1'b0);
        set_pool(32'h0000_0040, 16'd8, 9'd511);
        add_req(OP_INIT, '0, 1'b0);
        set_pool(32'h0000_0040, 16'd0, 9'd4);
        add_req(OP_INIT, '0, 1'b0);
        set_pool(32'h0000_0000, 16'd8, 9'd4);
        add_req(OP_INIT, '0, 1'b0);

        directed_total = items_queued;
        round          = 0;
        while (items_queued < directed_total + RANDOM_ITEMS)
        begin
            pick_pool_shape(base, bytes, count);
            set_pool(base, bytes, count);
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            if (round == 3 || round == 20)
            begin
                send_gaps     = 1'b0;
                long_hold_req = 1'b1;
            end
            add_req(OP_INIT, ADDR_W'($urandom()), 1'b0);
            queue_round($urandom_range(16, 40));
            round++;
        end
        wait_idle();

        $display("Ran %0d requests over %0d pool settings: %0d grants, %0d returns,",
                 req_accepted, n_settings, n_grants, n_returns);
        $display("%0d pool builds, %0d refused requests, %0d long output stalls.",
                 n_builds, n_refused, long_holds);
        if (fail_count == 0)
            $display("PASS fixed_block_pool_allocator_core");
        else
            $display("FAIL fixed_block_pool_allocator_core");
        $finish;
    end

endmodule
